@@ rtl/gtg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gtg_pkg;

   // Field widths.
   localparam int CoordW   = 32;
   localparam int AngleW   = 16;
   localparam int GainW    = 16;
   localparam int RateW    = 32;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;

   // CORDIC datapath: a 33 bit offset scaled by 2^16 with headroom for the gain.
   localparam int CordicW  = 52;
   localparam int FracW    = 16;
   localparam int TurnW    = 32;
   localparam int AtanIdxW = 5;
   localparam int AtanEntries = 24;
   localparam int CordicStepsDefault = 16;

   // Magnitude slice taken from the CORDIC x register.
   localparam int MagW = 34;
   localparam int MulW = 32;
   localparam int ProdW = 2 * MulW;

   localparam logic [MulW-1:0] InvKQ30  = 32'd652032874;
   localparam logic [MulW-1:0] TwoPiQ29 = 32'd3373259426;
   localparam logic [ProdW-1:0] TurnRound = 64'h0000_0010_0000_0000;

   // Register indexes.
   localparam logic [CsrIdxW-1:0] RegSpeedGain = 2'd0;
   localparam logic [CsrIdxW-1:0] RegTurnGain  = 2'd1;
   localparam logic [CsrIdxW-1:0] RegMaxSpeed  = 2'd2;

   localparam logic [GainW-1:0] SpeedGainReset = 16'd128;
   localparam logic [GainW-1:0] TurnGainReset  = 16'd256;
   localparam logic [GainW-1:0] MaxSpeedReset  = 16'd256;

   // Arctangent of 2^-i in units of 2^32 per turn.
   function automatic logic [TurnW-1:0] atan_turn(input logic [AtanIdxW-1:0] idx);
      logic [TurnW-1:0] t;
      unique case (idx)
         5'd0:  t = 32'd536870912;
         5'd1:  t = 32'd316933406;
         5'd2:  t = 32'd167458907;
         5'd3:  t = 32'd85004756;
         5'd4:  t = 32'd42667331;
         5'd5:  t = 32'd21354465;
         5'd6:  t = 32'd10679838;
         5'd7:  t = 32'd5340245;
         5'd8:  t = 32'd2670163;
         5'd9:  t = 32'd1335087;
         5'd10: t = 32'd667544;
         5'd11: t = 32'd333772;
         5'd12: t = 32'd166886;
         5'd13: t = 32'd83443;
         5'd14: t = 32'd41722;
         5'd15: t = 32'd20861;
         5'd16: t = 32'd10430;
         5'd17: t = 32'd5215;
         5'd18: t = 32'd2608;
         5'd19: t = 32'd1304;
         5'd20: t = 32'd652;
         5'd21: t = 32'd326;
         5'd22: t = 32'd163;
         5'd23: t = 32'd81;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

@@ rtl/gtg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface gtg_req_if;
   import gtg_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     goal_valid;
   logic                     pose_valid;
   logic signed [CoordW-1:0] goal_x;
   logic signed [CoordW-1:0] goal_y;
   logic signed [CoordW-1:0] pos_x;
   logic signed [CoordW-1:0] pos_y;
   logic [AngleW-1:0]        heading;

   modport source (output valid, goal_valid, pose_valid, goal_x, goal_y, pos_x, pos_y,
                   heading, input ready);
   modport sink (input valid, goal_valid, pose_valid, goal_x, goal_y, pos_x, pos_y,
                 heading, output ready);
endinterface

interface gtg_rsp_if;
   import gtg_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    ok;
   logic [GainW-1:0]        lin_speed_cmd;
   logic signed [RateW-1:0] turn_rate_cmd;

   modport source (output valid, ok, lin_speed_cmd, turn_rate_cmd, input ready);
   modport sink (input valid, ok, lin_speed_cmd, turn_rate_cmd, output ready);
endinterface

interface gtg_csr_if;
   import gtg_pkg::*;
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/gtg_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gtg_mul (
   input  logic                      clock,
   input  logic [gtg_pkg::MulW-1:0]  a,
   input  logic [gtg_pkg::MulW-1:0]  b,
   output logic [gtg_pkg::ProdW-1:0] prod
);
   import gtg_pkg::*;

   logic [ProdW-1:0] prod_ff;
   logic [ProdW-1:0] prod_in;

   assign prod_in = {{(ProdW-MulW){1'b0}}, a} * {{(ProdW-MulW){1'b0}}, b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

@@ rtl/gtg_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gtg_cordic #(
   parameter int STEPS = gtg_pkg::CordicStepsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [gtg_pkg::CoordW:0]   dx,
   input  logic signed [gtg_pkg::CoordW:0]   dy,
   output logic                              done,
   output logic signed [gtg_pkg::CordicW-1:0] x_out,
   output logic [gtg_pkg::TurnW-1:0]         ang_out
);
   import gtg_pkg::*;

   localparam int IterW = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [IterW-1:0] LastIter = IterW'(STEPS - 1);
   localparam int ExtW = CordicW - (CoordW + 1) - FracW;

   logic signed [CordicW-1:0] x_ff, y_ff;
   logic [TurnW-1:0]          ang_ff;
   logic [IterW-1:0]          iter_ff;
   logic                      busy_ff;
   logic                      done_ff;

   logic signed [CordicW-1:0] x_start, y_start;
   logic signed [CordicW-1:0] x_sh, y_sh;
   logic                      y_pos;
   logic [TurnW-1:0]          atan_step;

   assign x_start = {{ExtW{dx[CoordW]}}, dx, {FracW{1'b0}}};
   assign y_start = {{ExtW{dy[CoordW]}}, dy, {FracW{1'b0}}};

   // Arithmetic shifts round toward minus infinity, as the iteration needs.
   assign x_sh      = x_ff >>> iter_ff;
   assign y_sh      = y_ff >>> iter_ff;
   assign y_pos     = !y_ff[CordicW-1] && (y_ff != '0);
   assign atan_step = atan_turn(AtanIdxW'(iter_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
         end else if (busy_ff) begin
            if (iter_ff == LastIter) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               iter_ff <= iter_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         // A goal with a negative x offset is turned by a half turn first.
         if (dx[CoordW]) begin
            x_ff   <= -x_start;
            y_ff   <= -y_start;
            ang_ff <= 32'h8000_0000;
         end else begin
            x_ff   <= x_start;
            y_ff   <= y_start;
            ang_ff <= '0;
         end
      end else if (busy_ff) begin
         if (y_pos) begin
            x_ff   <= x_ff + y_sh;
            y_ff   <= y_ff - x_sh;
            ang_ff <= ang_ff + atan_step;
         end else begin
            x_ff   <= x_ff - y_sh;
            y_ff   <= y_ff + x_sh;
            ang_ff <= ang_ff - atan_step;
         end
      end
   end

   assign done    = done_ff;
   assign x_out   = x_ff;
   assign ang_out = ang_ff;

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("vectoring pass restarted while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("done raised while iterations remain");
   a_keep_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (iter_ff != LastIter) |=> busy_ff)
      else $error("vectoring pass ended early");
`endif

endmodule

`default_nettype wire

@@ rtl/go_to_goal_unicycle_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Port     Direction  Beat contents
// request   req_ch   in         goal_valid, pose_valid, goal_x, goal_y, pos_x, pos_y, heading
// response  rsp_ch   out        ok, lin_speed_cmd, turn_rate_cmd
// control   csr_ch   in         index, data (speed_gain, turn_gain, max_speed)
//
// A request with both flags set runs from accept to the response beat through
// one CORDIC iteration per cycle, then six 32x32 products through one shared
// multiplier. A request with a flag low goes straight to the response stage.
// Reset restores the default gains and clears the held command. The request side is
// ready once the previous result sits in the response register; a stalled response holds.
// Control writes are always ready.
module go_to_goal_unicycle_controller #(
   parameter int CORDIC_STEPS = gtg_pkg::CordicStepsDefault
) (
   input  logic      clock,
   input  logic      reset,
   gtg_req_if.sink   req_ch,
   gtg_rsp_if.source rsp_ch,
   gtg_csr_if.sink   csr_ch
);
   import gtg_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CORDIC = 2'd1;
   localparam logic [1:0] S_MATH   = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   localparam logic [2:0] OP_MAG_LO    = 3'd0;
   localparam logic [2:0] OP_MAG_HI    = 3'd1;
   localparam logic [2:0] OP_SPEED_LO  = 3'd2;
   localparam logic [2:0] OP_SPEED_HI  = 3'd3;
   localparam logic [2:0] OP_TURN_GAIN = 3'd4;
   localparam logic [2:0] OP_TURN_RAD  = 3'd5;

   logic [1:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic       phase_ff, phase_in;

   logic [GainW-1:0]  speed_gain_ff, turn_gain_ff, max_speed_ff;
   logic [GainW-1:0]  held_speed_ff;
   logic [RateW-1:0]  held_turn_ff;
   logic [AngleW-1:0] heading_ff;
   logic              zero_ff;
   logic              ok_ff;
   logic              neg_ff;
   logic [ProdW-1:0]  acc_ff;
   logic [MagW-1:0]   dist_ff;
   logic [MulW-1:0]   tprod_ff;

   logic              rsp_valid_ff;
   logic              rsp_ok_ff;
   logic [GainW-1:0]  rsp_speed_ff;
   logic [RateW-1:0]  rsp_turn_ff;

   logic                      accept;
   logic                      both_valid;
   logic signed [CoordW:0]    dx, dy;
   logic                      cordic_start;
   logic                      cordic_done;
   logic signed [CordicW-1:0] cordic_x;
   logic [TurnW-1:0]          cordic_ang;
   logic [TurnW-1:0]          ang_round;
   logic [MagW-1:0]           mag;
   logic [AngleW-1:0]         bearing;
   logic [AngleW-1:0]         err_raw;
   logic                      err_neg;
   logic [AngleW-1:0]         err_mag;
   logic [MulW-1:0]           mul_a, mul_b;
   logic [ProdW-1:0]          prod;
   logic [ProdW-1:0]          acc_sum;
   logic [ProdW-1:0]          turn_sum;
   logic [MagW-1:0]           speed_raw;
   logic [GainW-1:0]          speed_cap;
   logic [RateW-1:0]          turn_abs;
   logic                      rsp_free;

   assign accept       = req_ch.valid && req_ch.ready;
   assign both_valid   = req_ch.goal_valid && req_ch.pose_valid;
   assign dx           = {req_ch.goal_x[CoordW-1], req_ch.goal_x}
                         - {req_ch.pos_x[CoordW-1], req_ch.pos_x};
   assign dy           = {req_ch.goal_y[CoordW-1], req_ch.goal_y}
                         - {req_ch.pos_y[CoordW-1], req_ch.pos_y};
   assign cordic_start = accept && both_valid;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   gtg_cordic #(
      .STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .dx     (dx),
      .dy     (dy),
      .done   (cordic_done),
      .x_out  (cordic_x),
      .ang_out(cordic_ang)
   );

   gtg_mul u_mul (
      .clock(clock),
      .a    (mul_a),
      .b    (mul_b),
      .prod (prod)
   );

   // A goal exactly on the robot has no bearing; distance and bearing are both zero.
   assign mag       = zero_ff ? '0 : cordic_x[FracW+MagW-1:FracW];
   assign ang_round = cordic_ang + 32'h0000_8000;
   assign bearing   = zero_ff ? '0 : ang_round[TurnW-1:TurnW-AngleW];
   assign err_raw   = bearing - heading_ff;
   // An error of exactly half a turn counts as positive.
   assign err_neg   = err_raw[AngleW-1] && (err_raw != 16'h8000);
   assign err_mag   = err_neg ? (16'd0 - err_raw) : err_raw;

   always_comb begin
      unique case (op_ff)
         OP_MAG_LO: begin
            mul_a = mag[MulW-1:0];
            mul_b = InvKQ30;
         end
         OP_MAG_HI: begin
            mul_a = {{(2*MulW-MagW){1'b0}}, mag[MagW-1:MulW]};
            mul_b = InvKQ30;
         end
         OP_SPEED_LO: begin
            mul_a = {{(MulW-GainW){1'b0}}, speed_gain_ff};
            mul_b = dist_ff[MulW-1:0];
         end
         OP_SPEED_HI: begin
            mul_a = {{(MulW-GainW){1'b0}}, speed_gain_ff};
            mul_b = {{(2*MulW-MagW){1'b0}}, dist_ff[MagW-1:MulW]};
         end
         OP_TURN_GAIN: begin
            mul_a = {{(MulW-GainW){1'b0}}, turn_gain_ff};
            mul_b = {{(MulW-AngleW){1'b0}}, err_mag};
         end
         OP_TURN_RAD: begin
            mul_a = tprod_ff;
            mul_b = TwoPiQ29;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // High partial products carry only their low word; the upper word is known zero.
   assign acc_sum   = acc_ff + {prod[MulW-1:0], {MulW{1'b0}}};
   assign speed_raw = acc_sum[FracW+MagW-1:FracW];
   assign speed_cap = (speed_raw > {{(MagW-GainW){1'b0}}, max_speed_ff})
                      ? max_speed_ff : speed_raw[GainW-1:0];
   assign turn_sum  = prod + TurnRound;
   assign turn_abs  = {5'd0, turn_sum[ProdW-1:37]};

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = both_valid ? S_CORDIC : S_DONE;
            end
         end
         S_CORDIC: begin
            if (cordic_done) begin
               state_in = S_MATH;
               op_in    = OP_MAG_LO;
               phase_in = 1'b0;
            end
         end
         S_MATH: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (op_ff == OP_TURN_RAD) begin
                  state_in = S_DONE;
               end else begin
                  op_in = op_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= OP_MAG_LO;
         phase_ff      <= 1'b0;
         speed_gain_ff <= SpeedGainReset;
         turn_gain_ff  <= TurnGainReset;
         max_speed_ff  <= MaxSpeedReset;
         held_speed_ff <= '0;
         held_turn_ff  <= '0;
         ok_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         phase_ff <= phase_in;

         if (csr_ch.valid) begin
            case (csr_ch.index)
               RegSpeedGain: speed_gain_ff <= csr_ch.data;
               RegTurnGain:  turn_gain_ff  <= csr_ch.data;
               RegMaxSpeed:  max_speed_ff  <= csr_ch.data;
               default: ;
            endcase
         end

         if (accept) begin
            ok_ff <= both_valid;
         end

         // Products are consumed in the cycle after they were issued.
         if (state_ff == S_MATH && phase_ff) begin
            unique case (op_ff)
               OP_SPEED_HI: held_speed_ff <= speed_cap;
               OP_TURN_RAD: held_turn_ff  <= neg_ff ? (32'd0 - turn_abs) : turn_abs;
               default: ;
            endcase
         end

         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         heading_ff <= req_ch.heading;
         zero_ff    <= (dx == '0) && (dy == '0);
      end
      if (state_ff == S_MATH && phase_ff) begin
         unique case (op_ff)
            OP_MAG_LO:    acc_ff   <= prod;
            OP_MAG_HI:    dist_ff  <= acc_sum[ProdW-1:ProdW-MagW];
            OP_SPEED_LO:  acc_ff   <= prod;
            OP_TURN_GAIN: begin
               tprod_ff <= prod[MulW-1:0];
               neg_ff   <= err_neg;
            end
            default: ;
         endcase
      end
      if (state_ff == S_DONE && rsp_free) begin
         rsp_ok_ff    <= ok_ff;
         rsp_speed_ff <= held_speed_ff;
         rsp_turn_ff  <= held_turn_ff;
      end
   end

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ok            = rsp_ok_ff;
   assign rsp_ch.lin_speed_cmd = rsp_speed_ff;
   assign rsp_ch.turn_rate_cmd = rsp_turn_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("request accepted but sequencer stayed idle");
   a_done_in_cordic: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == S_CORDIC)
      else $error("vectoring result arrived outside its wait state");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised without a finished request");
`endif

endmodule

`default_nettype wire

@@ test/go_to_goal_unicycle_controller_tb.sv @@
`timescale 1ns / 1ps

module go_to_goal_unicycle_controller_tb;
   import gtg_pkg::*;

   localparam int Steps = CordicStepsDefault;
   // Accept to response for a request with both flags set.
   localparam int Latency = Steps + 14;
   localparam logic [CsrIdxW-1:0] RegSpare = 2'd3;
   localparam logic signed [CoordW-1:0] CoordMax = 32'sh7FFF_FFFF;
   localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;

   typedef struct packed {
      logic             ok;
      logic [GainW-1:0] speed;
      logic [RateW-1:0] turn;
   } drive_cmd_type;

   logic clock;
   logic reset;

   gtg_req_if req_ch ();
   gtg_rsp_if rsp_ch ();
   gtg_csr_if csr_ch ();

   go_to_goal_unicycle_controller #(
      .CORDIC_STEPS(Steps)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // Controller state as the block should hold it.
   logic [GainW-1:0] k_speed = SpeedGainReset;
   logic [GainW-1:0] k_turn = TurnGainReset;
   logic [GainW-1:0] speed_cap = MaxSpeedReset;
   logic [GainW-1:0] held_speed_cmd = '0;
   logic [RateW-1:0] held_turn_cmd = '0;

   logic [TurnW-1:0] atan_turns [0:AtanEntries-1];
   drive_cmd_type pending_cmds [$];
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   bit steady_flow = 1'b0;

   initial begin
      atan_turns = '{
         32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
         32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
         32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
         32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
      };
   end

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic int unsigned idle_cycles();
      if (steady_flow) return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic drive_cmd_type steer_to_goal(
      input logic gv,
      input logic pv,
      input logic signed [CoordW-1:0] gx,
      input logic signed [CoordW-1:0] gy,
      input logic signed [CoordW-1:0] px,
      input logic signed [CoordW-1:0] py,
      input logic [AngleW-1:0] hdg
   );
      drive_cmd_type cmd;
      longint x;
      longint y;
      longint xs;
      longint ys;
      logic [63:0] x_mag;
      logic [TurnW-1:0] ang;
      logic [63:0] distance;
      logic [63:0] spd;
      logic [63:0] mag;
      logic [63:0] w;
      logic [AngleW-1:0] bearing;
      logic [AngleW-1:0] err_raw;
      int err;
      logic [RateW-1:0] rate;
      if (gv && pv) begin
         x = (longint'(gx) - longint'(px)) * 65536;
         y = (longint'(gy) - longint'(py)) * 65536;
         ang = '0;
         distance = '0;
         bearing = '0;
         if (x != 0 || y != 0) begin
            // Fold the left half plane onto the right one before vectoring.
            if (x < 0) begin
               x = -x;
               y = -y;
               ang = 32'h8000_0000;
            end
            for (int i = 0; i < Steps && i < AtanEntries; i++) begin
               xs = x >>> i;
               ys = y >>> i;
               if (y > 0) begin
                  x = x + ys;
                  y = y - xs;
                  ang = ang + atan_turns[i];
               end else begin
                  x = x - ys;
                  y = y + xs;
                  ang = ang - atan_turns[i];
               end
            end
            x_mag = x;
            distance = ((x_mag >> FracW) * 64'(InvKQ30)) >> 30;
            bearing = AngleW'((64'(ang) + 64'h8000) >> 16);
         end
         spd = (64'(k_speed) * distance) >> 16;
         if (spd > 64'(speed_cap)) spd = 64'(speed_cap);
         // The error is read as -32767..32768, so an exact half turn turns left.
         err_raw = bearing - hdg;
         err = (err_raw > 16'h8000) ? int'(err_raw) - 65536 : int'(err_raw);
         mag = (err < 0) ? 64'(-err) : 64'(err);
         w = (64'(k_turn) * mag * 64'(TwoPiQ29) + TurnRound) >> 37;
         rate = w[RateW-1:0];
         if (err < 0) rate = -rate;
         held_speed_cmd = spd[GainW-1:0];
         held_turn_cmd = rate;
         cmd.ok = 1'b1;
      end else begin
         cmd.ok = 1'b0;
      end
      cmd.speed = held_speed_cmd;
      cmd.turn = held_turn_cmd;
      return cmd;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatches++;
      if (mismatches <= 100)
         $display("mismatch in %s of result %0d: expected %0h, got %0h",
                  what, results_seen, want, got);
   endtask

   task automatic send_pose(
      input logic gv,
      input logic pv,
      input logic signed [CoordW-1:0] gx,
      input logic signed [CoordW-1:0] gy,
      input logic signed [CoordW-1:0] px,
      input logic signed [CoordW-1:0] py,
      input logic [AngleW-1:0] hdg
   );
      int unsigned gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.goal_valid <= gv;
      req_ch.pose_valid <= pv;
      req_ch.goal_x <= gx;
      req_ch.goal_y <= gy;
      req_ch.pos_x <= px;
      req_ch.pos_y <= py;
      req_ch.heading <= hdg;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      pending_cmds.push_back(steer_to_goal(gv, pv, gx, gy, px, py, hdg));
   endtask

   task automatic wait_for_commands();
      req_ch.valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
   endtask

   // Leaves the write channel valid so that writes can follow back to back.
   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] value);
      csr_ch.index <= idx;
      csr_ch.data <= value;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         RegSpeedGain: k_speed = value;
         RegTurnGain:  k_turn = value;
         RegMaxSpeed:  speed_cap = value;
         default: ;
      endcase
   endtask

   task automatic set_gains(input logic [GainW-1:0] sg, input logic [GainW-1:0] tg,
                            input logic [GainW-1:0] cap);
      wait_for_commands();
      write_reg(RegSpeedGain, sg);
      write_reg(RegTurnGain, tg);
      write_reg(RegMaxSpeed, cap);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_pose(1'b0, 1'b1, 32'sd100, 32'sd0, 32'sd0, 32'sd0, 16'h0000);
      send_pose(1'b1, 1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'h0000);
      send_pose(1'b1, 1'b1, 32'sd5, 32'sd5, 32'sd5, 32'sd5, 16'h8000);
      send_pose(1'b1, 1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'h7FFF);
      send_pose(1'b1, 1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'h8001);
      send_pose(1'b1, 1'b1, CoordMax, CoordMax, CoordMin, CoordMin, 16'hFFFF);
      send_pose(1'b1, 1'b1, CoordMin, CoordMin, CoordMax, CoordMax, 16'h0000);
      send_pose(1'b1, 1'b1, CoordMin, 32'sd0, 32'sd0, 32'sd0, 16'h0000);
      send_pose(1'b1, 1'b1, 32'sh0001_0000, 32'sh0001_0000, 32'sd0, 32'sd0, 16'h2000);
      send_pose(1'b1, 1'b0, 32'sd0, 32'sh0001_0000, 32'sd0, 32'sd0, 16'h4000);
      send_pose(1'b1, 1'b1, 32'sd0, 32'sh0001_0000, 32'sd0, 32'sd0, 16'h4000);
      send_pose(1'b1, 1'b0, CoordMax, CoordMax, CoordMax, CoordMax, 16'hFFFF);
      send_pose(1'b0, 1'b0, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 16'hFFFF);
      send_pose(1'b1, 1'b1, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 16'h0000);
   endtask

   task automatic test_register_extremes();
      set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pose(1'b1, 1'b1, CoordMax, CoordMin, CoordMin, CoordMax, 16'h1234);
      send_pose(1'b1, 1'b1, 32'sh0003_0000, -32'sh0002_0000, 32'sd0, 32'sd0, 16'hC000);
      send_pose(1'b1, 1'b1, -32'sd7, -32'sd7, -32'sd7, -32'sd7, 16'h8000);
      set_gains(16'h0000, 16'h0000, 16'h0000);
      send_pose(1'b1, 1'b1, CoordMax, CoordMax, CoordMin, CoordMin, 16'h4321);
      send_pose(1'b1, 1'b1, 32'sh0000_8000, 32'sd0, 32'sd0, 32'sd0, 16'hFFFF);
      // A write to the spare index must leave every gain alone.
      wait_for_commands();
      write_reg(RegSpare, 16'hFFFF);
      csr_ch.valid <= 1'b0;
      send_pose(1'b1, 1'b1, 32'sh0004_0000, 32'sh0001_0000, 32'sd0, 32'sd0, 16'h0100);
   endtask

   task automatic test_random_poses(input int unsigned count, input bit no_gaps);
      logic gv;
      logic pv;
      logic signed [CoordW-1:0] gx;
      logic signed [CoordW-1:0] gy;
      logic signed [CoordW-1:0] px;
      logic signed [CoordW-1:0] py;
      logic signed [CoordW-1:0] off_x;
      logic signed [CoordW-1:0] off_y;
      logic [AngleW-1:0] hdg;
      int unsigned pick;
      int unsigned sh;
      steady_flow = no_gaps;
      repeat (count) begin
         // Mostly well-formed poses; now and then a missing goal or odometry beat.
         pick = $urandom_range(0, 9);
         gv = (pick == 0) ? 1'b0 : 1'b1;
         pv = (pick == 1) ? 1'b0 : ((pick == 2) ? 1'($urandom_range(0, 1)) : 1'b1);
         px = $urandom;
         py = $urandom;
         hdg = AngleW'($urandom_range(0, 65535));
         pick = $urandom_range(0, 7);
         if (pick == 0) begin
            gx = $urandom;
            gy = $urandom;
         end else if (pick == 7) begin
            gx = px;
            gy = py;
         end else begin
            sh = $urandom_range(0, 31);
            off_x = $urandom;
            off_y = $urandom;
            off_x = off_x >>> sh;
            off_y = off_y >>> sh;
            gx = px + off_x;
            gy = py + off_y;
         end
         send_pose(gv, pv, gx, gy, px, py, hdg);
      end
      steady_flow = 1'b0;
   endtask

   initial begin : command_collector
      drive_cmd_type want;
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         results_seen++;
         if (pending_cmds.size() == 0) begin
            report_mismatch("unexpected beat", '0, {rsp_ch.ok, rsp_ch.lin_speed_cmd});
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_ch.ok !== want.ok)
               report_mismatch("ok", want.ok, rsp_ch.ok);
            if (rsp_ch.lin_speed_cmd !== want.speed)
               report_mismatch("lin_speed_cmd", want.speed, rsp_ch.lin_speed_cmd);
            if (rsp_ch.turn_rate_cmd !== want.turn)
               report_mismatch("turn_rate_cmd", want.turn, rsp_ch.turn_rate_cmd);
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.goal_valid <= 1'b0;
      req_ch.pose_valid <= 1'b0;
      req_ch.goal_x <= '0;
      req_ch.goal_y <= '0;
      req_ch.pos_x <= '0;
      req_ch.pos_y <= '0;
      req_ch.heading <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      set_gains(SpeedGainReset, TurnGainReset, MaxSpeedReset);
      test_random_poses(120, 1'b0);
      set_gains(GainW'($urandom_range(0, 65535)), GainW'($urandom_range(0, 65535)),
                GainW'($urandom_range(0, 65535)));
      test_random_poses(120, 1'b0);
      set_gains(GainW'($urandom_range(0, 1023)), GainW'($urandom_range(0, 65535)), 16'hFFFF);
      test_random_poses(100, 1'b1);
      set_gains(16'hFFFF, 16'h0001, GainW'($urandom_range(0, 2048)));
      test_random_poses(80, 1'b0);
      set_gains(GainW'($urandom_range(1, 512)), GainW'($urandom_range(1, 512)),
                GainW'($urandom_range(64, 1024)));
      test_random_poses(80, 1'b0);

      wait_for_commands();
      repeat (Latency + 10) @(posedge clock);
      if (mismatches == 0 && pending_cmds.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
